### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/etmm_pkg.sv
// Package for the Euler TRS model matrix block: constants, payload types,
// the series divisors and the Q30 rounding helper. No dependencies.
`default_nettype none

package etmm_pkg;

    // Latency of the sine/cosine pipeline and of the matrix stages.
    localparam int SC_LAT = 25;
    localparam int MX_LAT = 6;
    localparam int TOT_LAT = SC_LAT + MX_LAT;

    localparam logic [24:0] DEG90 = 25'd5898240;
    localparam logic [24:0] DEG45 = 25'd2949120;
    // floor(2^16 / 45) + 1; the quotient is never low, at most one high
    localparam logic [10:0] RECIP45 = 11'd1457;

    // pi/180 in Q46, split for two narrower multipliers
    localparam logic [40:0] RAD_Q46 = 41'd1228166276394;
    localparam logic [20:0] RAD_HI = RAD_Q46[40:20];
    localparam logic [19:0] RAD_LO = RAD_Q46[19:0];

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    localparam logic signed [65:0] SAT_MAX = 66'sh0_7FFF_FFFF;
    localparam logic signed [65:0] SAT_MIN = -66'sh0_8000_0000;

    typedef struct packed {
        logic [29:0]        x2;
        logic signed [31:0] s;
        logic signed [31:0] c;
        logic               swap;
        logic [1:0]         quad;
    } sc_ctx_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } carry_t;

    // entry i*4+j holds row i column j
    typedef logic [11:0][31:0] mat_t;

    function automatic int sin_div(input int k);
        case (k)
            1:       return 6;
            2:       return 20;
            3:       return 42;
            4:       return 72;
            5:       return 110;
            default: return 2;
        endcase
    endfunction

    function automatic int cos_div(input int k);
        case (k)
            1:       return 2;
            2:       return 12;
            3:       return 30;
            4:       return 56;
            5:       return 90;
            6:       return 132;
            default: return 2;
        endcase
    endfunction

    // (p >> 30) rounded to nearest, ties away from zero
    function automatic logic signed [65:0] rnd30(input logic signed [65:0] p);
        logic [65:0] m;
        m = p[65] ? (~p + 66'd1) : p;
        m = (m + (66'd1 << 29)) >> 30;
        return p[65] ? $signed(~m + 66'd1) : $signed(m);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/etmm_sincos.sv
// Pipelined sine and cosine of an angle in degrees (Q16.16) to Q2.30.
// Depends on etmm_pkg. The pipeline advances only while ce is high.
`default_nettype none

module etmm_sincos (
    input  logic               clk,
    input  logic               ce,
    input  logic signed [31:0] angle,
    output logic signed [31:0] sin_q30,
    output logic signed [31:0] cos_q30
);

    // stage 1: split angle = hi*2^19 + lo, bias hi by a multiple of 45 so it is non-negative
    logic signed [14:0] hu_wide;
    logic [13:0]        hu_next;
    logic [13:0]        hu_reg;
    logic [18:0]        lo1_reg;
    logic [23:0]        hq_reg;

    assign hu_wide = $signed({{2{angle[31]}}, angle[31:19]}) + 15'sd4140;
    assign hu_next = hu_wide[13:0];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            hu_reg  <= hu_next;
            lo1_reg <= angle[18:0];
            hq_reg  <= 24'(hu_next) * 24'(etmm_pkg::RECIP45);
        end
    end

    // stage 2: hi mod 45, then quadrant and remainder
    logic [7:0]         q45;
    logic signed [14:0] hm_raw;
    logic [5:0]         hm;
    logic [24:0]        r_full;
    logic [7:0]         r_top;
    logic [1:0]         quad_next;
    logic [24:0]        rem_full;
    logic [1:0]         quad2_reg;
    logic [22:0]        rem2_reg;

    always_comb
    begin
        q45    = hq_reg[23:16];
        hm_raw = $signed({1'b0, hu_reg}) - $signed({1'b0, 14'(q45) * 14'd45});
        hm     = hm_raw[14] ? 6'(hm_raw + 15'sd45) : 6'(hm_raw);
        r_full = {hm, lo1_reg};
        r_top  = r_full[24:17];
        if (r_top >= 8'd135)
            quad_next = 2'd3;
        else if (r_top >= 8'd90)
            quad_next = 2'd2;
        else if (r_top >= 8'd45)
            quad_next = 2'd1;
        else
            quad_next = 2'd0;
        rem_full = r_full - 25'(quad_next) * etmm_pkg::DEG90;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            quad2_reg <= quad_next;
            rem2_reg  <= rem_full[22:0];
        end
    end

    // stage 3: fold above 45 degrees, degrees to radians (two partial products)
    logic        swap_next;
    logic [21:0] remc;
    logic [42:0] ph3_reg;
    logic [41:0] pl3_reg;
    logic        swap3_reg;
    logic [1:0]  quad3_reg;

    always_comb
    begin
        swap_next = 25'(rem2_reg) > etmm_pkg::DEG45;
        remc = swap_next ? 22'(etmm_pkg::DEG90 - 25'(rem2_reg)) : rem2_reg[21:0];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ph3_reg   <= 43'(remc) * 43'(etmm_pkg::RAD_HI);
            pl3_reg   <= 42'(remc) * 42'(etmm_pkg::RAD_LO);
            swap3_reg <= swap_next;
            quad3_reg <= quad2_reg;
        end
    end

    // stage 4: x = round(rem * pi/180), Q2.30
    logic [63:0] xsum;
    logic [29:0] x4_reg;
    logic        swap4_reg;
    logic [1:0]  quad4_reg;

    assign xsum = {1'b0, ph3_reg, 20'd0} + 64'(pl3_reg) + (64'd1 << 31);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x4_reg    <= xsum[61:32];
            swap4_reg <= swap3_reg;
            quad4_reg <= quad3_reg;
        end
    end

    // stage 5: x*x
    logic [59:0] xx5_reg;
    logic [29:0] x5_reg;
    logic        swap5_reg;
    logic [1:0]  quad5_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            xx5_reg   <= 60'(x4_reg) * 60'(x4_reg);
            x5_reg    <= x4_reg;
            swap5_reg <= swap4_reg;
            quad5_reg <= quad4_reg;
        end
    end

    // stage 6: x^2 rounded, series seeds
    logic [60:0]         x2sum;
    etmm_pkg::sc_ctx_t   ctx_c [0:6];
    logic [30:0]         ts_c  [0:6];
    logic [30:0]         tc_c  [0:6];

    assign x2sum = {1'b0, xx5_reg} + (61'd1 << 29);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ctx_c[0].x2   <= x2sum[59:30];
            ctx_c[0].s    <= $signed({2'b00, x5_reg});
            ctx_c[0].c    <= $signed({1'b0, etmm_pkg::Q30_ONE});
            ctx_c[0].swap <= swap5_reg;
            ctx_c[0].quad <= quad5_reg;
            ts_c[0]       <= {1'b0, x5_reg};
            tc_c[0]       <= etmm_pkg::Q30_ONE;
        end
    end

    // series terms: three stages each (multiply, scale by reciprocal, correct)
    etmm_pkg::sc_ctx_t ctx_a [1:6];
    etmm_pkg::sc_ctx_t ctx_b [1:6];
    logic [60:0]       ps_a  [1:6];
    logic [60:0]       pc_a  [1:6];
    logic [30:0]       ns_b  [1:6];
    logic [30:0]       nc_b  [1:6];
    logic [62:0]       ms_b  [1:6];
    logic [62:0]       mc_b  [1:6];

    genvar k;
    generate
        for (k = 1; k <= 6; k++)
        begin : g_term
            localparam int DS = etmm_pkg::sin_div(k);
            localparam int DC = etmm_pkg::cos_div(k);
            localparam logic [31:0] MS = 32'((64'd1 << 32) / DS);
            localparam logic [31:0] MC = 32'((64'd1 << 32) / DC);
            localparam bit SIN_ON = (k <= 5);
            localparam bit SUB = (k % 2 == 1);

            logic [60:0]  rs_sum;
            logic [60:0]  rc_sum;
            logic [30:0]  ns_next;
            logic [30:0]  nc_next;
            logic [30:0]  qs0;
            logic [30:0]  qc0;
            logic [39:0]  rs_rem;
            logic [39:0]  rc_rem;
            logic [30:0]  qs;
            logic [30:0]  qc;
            logic signed [31:0] s_next;
            logic signed [31:0] c_next;

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    ctx_a[k] <= ctx_c[k-1];
                    ps_a[k]  <= 61'(ts_c[k-1]) * 61'(ctx_c[k-1].x2);
                    pc_a[k]  <= 61'(tc_c[k-1]) * 61'(ctx_c[k-1].x2);
                end
            end

            always_comb
            begin
                rs_sum  = ps_a[k] + (61'd1 << 29);
                rc_sum  = pc_a[k] + (61'd1 << 29);
                ns_next = rs_sum[60:30] + 31'(DS / 2);
                nc_next = rc_sum[60:30] + 31'(DC / 2);
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    ctx_b[k] <= ctx_a[k];
                    ns_b[k]  <= ns_next;
                    nc_b[k]  <= nc_next;
                    ms_b[k]  <= 63'(ns_next) * 63'(MS);
                    mc_b[k]  <= 63'(nc_next) * 63'(MC);
                end
            end

            // reciprocal quotient is exact or one low
            always_comb
            begin
                qs0    = ms_b[k][62:32];
                qc0    = mc_b[k][62:32];
                rs_rem = 40'(ns_b[k]) - 40'(qs0) * 40'(DS);
                rc_rem = 40'(nc_b[k]) - 40'(qc0) * 40'(DC);
                qs     = (rs_rem >= 40'(DS)) ? qs0 + 31'd1 : qs0;
                qc     = (rc_rem >= 40'(DC)) ? qc0 + 31'd1 : qc0;
                if (!SIN_ON)
                    s_next = ctx_b[k].s;
                else if (SUB)
                    s_next = ctx_b[k].s - $signed({1'b0, qs});
                else
                    s_next = ctx_b[k].s + $signed({1'b0, qs});
                if (SUB)
                    c_next = ctx_b[k].c - $signed({1'b0, qc});
                else
                    c_next = ctx_b[k].c + $signed({1'b0, qc});
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    ctx_c[k].x2   <= ctx_b[k].x2;
                    ctx_c[k].s    <= s_next;
                    ctx_c[k].c    <= c_next;
                    ctx_c[k].swap <= ctx_b[k].swap;
                    ctx_c[k].quad <= ctx_b[k].quad;
                    ts_c[k]       <= qs;
                    tc_c[k]       <= qc;
                end
            end
        end
    endgenerate

    // final stage: undo the fold, apply quadrant signs
    logic signed [31:0] sf;
    logic signed [31:0] cf;
    logic signed [31:0] sin_next;
    logic signed [31:0] cos_next;
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;

    always_comb
    begin
        sf = ctx_c[6].swap ? ctx_c[6].c : ctx_c[6].s;
        cf = ctx_c[6].swap ? ctx_c[6].s : ctx_c[6].c;
        case (ctx_c[6].quad)
            2'd0:
            begin
                sin_next = sf;
                cos_next = cf;
            end
            2'd1:
            begin
                sin_next = cf;
                cos_next = -sf;
            end
            2'd2:
            begin
                sin_next = -sf;
                cos_next = -cf;
            end
            default:
            begin
                sin_next = -cf;
                cos_next = sf;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule

`default_nettype wire

### hw/rtl/euler_trs_model_matrix.sv
// Top level: model matrix T*Rx*Ry*Rz*S from position, Euler angles, scale.
// Depends on etmm_pkg, etmm_sincos and assert_macros.svh.
//
//   channel | handshake              | payload
//   --------+------------------------+----------------------------------
//   input   | in_valid / in_stall    | pos_*, angle_*_deg, scale_*
//   output  | out_valid / out_stall  | m_r0_c0 .. m_r2_c3
//
// One item per cycle while in_stall is low. The sine/cosine series pipeline
// is followed by the matrix product stages, then the output register.
// A skid register behind the pipeline absorbs one item when the output
// stalls; the whole pipeline then holds while in_stall is high.
// Reset clears the valid bits only.
`default_nettype none

module euler_trs_model_matrix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] angle_x_deg,
    input  logic signed [31:0] angle_y_deg,
    input  logic signed [31:0] angle_z_deg,
    input  logic signed [31:0] scale_x,
    input  logic signed [31:0] scale_y,
    input  logic signed [31:0] scale_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] m_r0_c0,
    output logic signed [31:0] m_r0_c1,
    output logic signed [31:0] m_r0_c2,
    output logic signed [31:0] m_r0_c3,
    output logic signed [31:0] m_r1_c0,
    output logic signed [31:0] m_r1_c1,
    output logic signed [31:0] m_r1_c2,
    output logic signed [31:0] m_r1_c3,
    output logic signed [31:0] m_r2_c0,
    output logic signed [31:0] m_r2_c1,
    output logic signed [31:0] m_r2_c2,
    output logic signed [31:0] m_r2_c3
);

    localparam int TOT = etmm_pkg::TOT_LAT;
    localparam int SCL = etmm_pkg::SC_LAT;

    logic ce;
    logic skid_valid_reg;
    logic out_valid_reg;
    logic [TOT-1:0] vld_reg;

    assign ce       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (ce)
            vld_reg <= {vld_reg[TOT-2:0], in_valid};
    end

    // position and scale ride alongside the trig pipeline
    etmm_pkg::carry_t dly_reg [SCL];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dly_reg[0] <= '{pos_x, pos_y, pos_z, scale_x, scale_y, scale_z};
            for (int i = 1; i < SCL; i++)
                dly_reg[i] <= dly_reg[i-1];
        end
    end

    logic signed [31:0] sx, cx, sy, cy, sz, cz;

    etmm_sincos u_sc_x (.clk(clk), .ce(ce), .angle(angle_x_deg), .sin_q30(sx), .cos_q30(cx));
    etmm_sincos u_sc_y (.clk(clk), .ce(ce), .angle(angle_y_deg), .sin_q30(sy), .cos_q30(cy));
    etmm_sincos u_sc_z (.clk(clk), .ce(ce), .angle(angle_z_deg), .sin_q30(sz), .cos_q30(cz));

    // T1: first-level raw products
    // order: sxsy cxsy cycz cysz cxsz cxcz sxcy sxsz sxcz cxcy
    logic signed [63:0] p1_reg [10];
    logic signed [31:0] cz1_reg, sz1_reg, sy1_reg;
    etmm_pkg::carry_t   car1_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p1_reg[0] <= 64'(sx) * 64'(sy);
            p1_reg[1] <= 64'(cx) * 64'(sy);
            p1_reg[2] <= 64'(cy) * 64'(cz);
            p1_reg[3] <= 64'(cy) * 64'(sz);
            p1_reg[4] <= 64'(cx) * 64'(sz);
            p1_reg[5] <= 64'(cx) * 64'(cz);
            p1_reg[6] <= 64'(sx) * 64'(cy);
            p1_reg[7] <= 64'(sx) * 64'(sz);
            p1_reg[8] <= 64'(sx) * 64'(cz);
            p1_reg[9] <= 64'(cx) * 64'(cy);
            cz1_reg   <= cz;
            sz1_reg   <= sz;
            sy1_reg   <= sy;
            car1_reg  <= dly_reg[SCL-1];
        end
    end

    // T2: round to Q2.30
    logic signed [31:0] q2_reg [10];
    logic signed [31:0] cz2_reg, sz2_reg, sy2_reg;
    etmm_pkg::carry_t   car2_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 10; i++)
                q2_reg[i] <= 32'(etmm_pkg::rnd30(66'(p1_reg[i])));
            cz2_reg  <= cz1_reg;
            sz2_reg  <= sz1_reg;
            sy2_reg  <= sy1_reg;
            car2_reg <= car1_reg;
        end
    end

    // T3: second-level raw products
    logic signed [63:0] p3_reg [4];
    logic signed [31:0] q3_reg [10];
    logic signed [31:0] sy3_reg;
    etmm_pkg::carry_t   car3_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p3_reg[0] <= 64'(q2_reg[0]) * 64'(cz2_reg);
            p3_reg[1] <= 64'(q2_reg[0]) * 64'(sz2_reg);
            p3_reg[2] <= 64'(q2_reg[1]) * 64'(cz2_reg);
            p3_reg[3] <= 64'(q2_reg[1]) * 64'(sz2_reg);
            q3_reg    <= q2_reg;
            sy3_reg   <= sy2_reg;
            car3_reg  <= car2_reg;
        end
    end

    // T4: rotation entries, index i*3+j
    logic signed [33:0] rot_next [9];
    logic signed [33:0] r4 [4];
    logic signed [33:0] rot4_reg [9];
    etmm_pkg::carry_t   car4_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            r4[i] = 34'(etmm_pkg::rnd30(66'(p3_reg[i])));
        rot_next[0] = 34'(q3_reg[2]);
        rot_next[1] = -34'(q3_reg[3]);
        rot_next[2] = 34'(sy3_reg);
        rot_next[3] = r4[0] + 34'(q3_reg[4]);
        rot_next[4] = -r4[1] + 34'(q3_reg[5]);
        rot_next[5] = -34'(q3_reg[6]);
        rot_next[6] = -r4[2] + 34'(q3_reg[7]);
        rot_next[7] = r4[3] + 34'(q3_reg[8]);
        rot_next[8] = 34'(q3_reg[9]);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rot4_reg <= rot_next;
            car4_reg <= car3_reg;
        end
    end

    // T5: scale columns
    logic signed [31:0] col_scale [3];
    logic signed [65:0] p5_reg [9];
    logic signed [31:0] pos5_reg [3];

    assign col_scale[0] = car4_reg.scale_x;
    assign col_scale[1] = car4_reg.scale_y;
    assign col_scale[2] = car4_reg.scale_z;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 9; i++)
                p5_reg[i] <= 66'(rot4_reg[i]) * 66'(col_scale[i % 3]);
            pos5_reg[0] <= car4_reg.pos_x;
            pos5_reg[1] <= car4_reg.pos_y;
            pos5_reg[2] <= car4_reg.pos_z;
        end
    end

    // T6: round and saturate
    logic signed [65:0] v6 [9];
    logic signed [31:0] res_next [9];
    etmm_pkg::mat_t     tail_reg;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            v6[i] = etmm_pkg::rnd30(p5_reg[i]);
            if (v6[i] > etmm_pkg::SAT_MAX)
                res_next[i] = 32'h7FFF_FFFF;
            else if (v6[i] < etmm_pkg::SAT_MIN)
                res_next[i] = 32'h8000_0000;
            else
                res_next[i] = 32'(v6[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                    tail_reg[r*4+c] <= res_next[r*3+c];
                tail_reg[r*4+3] <= pos5_reg[r];
            end
        end
    end

    // output register with skid
    logic           tail_valid;
    logic           out_ready;
    etmm_pkg::mat_t skid_reg;
    etmm_pkg::mat_t out_reg;

    assign tail_valid = vld_reg[TOT-1];
    assign out_ready  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= tail_valid;
        end
        else if (tail_valid && ce)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
            out_reg <= skid_valid_reg ? skid_reg : tail_reg;
        else if (tail_valid && ce)
            skid_reg <= tail_reg;
    end

    assign out_valid = out_valid_reg;
    assign m_r0_c0 = out_reg[0];
    assign m_r0_c1 = out_reg[1];
    assign m_r0_c2 = out_reg[2];
    assign m_r0_c3 = out_reg[3];
    assign m_r1_c0 = out_reg[4];
    assign m_r1_c1 = out_reg[5];
    assign m_r1_c2 = out_reg[6];
    assign m_r1_c3 = out_reg[7];
    assign m_r2_c0 = out_reg[8];
    assign m_r2_c1 = out_reg[9];
    assign m_r2_c2 = out_reg[10];
    assign m_r2_c3 = out_reg[11];

`include "assert_macros.svh"

    `ASSERT_SAME(a_skid_only_behind_out, skid_valid_reg, out_valid_reg)
    `ASSERT_NEXT(a_skid_drains, skid_valid_reg && !out_stall, out_valid_reg && !skid_valid_reg)
    `ASSERT_NEXT(a_tail_caught, out_valid_reg && out_stall && tail_valid && !skid_valid_reg, skid_valid_reg)
    `ASSERT_NEXT(a_pipe_holds, !ce, $stable(vld_reg))

endmodule

`default_nettype wire
